FILE: sv/jsf_pkg.sv
`timescale 1ns / 1ps

package jsf_pkg;

    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 16;
    localparam int NEST_W   = 8;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 8;

    localparam logic [STATUS_W-1:0] ST_SKIP  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BYTE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DONE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DROP  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FATAL = 3'd4;

    localparam logic [INDEX_W-1:0] REG_MAX_EVENT_BYTES = 8'd0;
    localparam logic [INDEX_W-1:0] REG_MAX_NESTING     = 8'd1;

    localparam logic [COUNT_W-1:0] MAX_EVENT_BYTES_RST = 16'd4096;
    localparam logic [NEST_W-1:0]  MAX_NESTING_RST     = 8'd16;
    localparam logic [COUNT_W-1:0] LEVEL_LIMIT         = 16'hFFFF;

    localparam logic [BYTE_W-1:0] CH_LBRACKET = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_RBRACKET = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_COMMA    = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_LBRACE   = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RBRACE   = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_BSLASH   = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_QUOTE    = 8'h22;
    localparam logic [BYTE_W-1:0] CH_SPACE    = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB      = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR       = 8'h0D;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   data_byte;
        logic                byte_kept;
        logic [COUNT_W-1:0]  event_length;
    } result_t;

    function automatic logic is_ws(input logic [BYTE_W-1:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

endpackage

FILE: sv/jsf_core.sv
`timescale 1ns / 1ps

module jsf_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [jsf_pkg::INDEX_W-1:0]   cfg_index,
    input  logic [jsf_pkg::COUNT_W-1:0]   cfg_data,
    input  logic                          push,
    input  logic [jsf_pkg::BYTE_W-1:0]    in_byte,
    output jsf_pkg::result_t              result
);

    logic [jsf_pkg::COUNT_W-1:0] max_event_bytes_reg;
    logic [jsf_pkg::NEST_W-1:0]  max_nesting_reg;

    logic outer_open_reg, outer_open_next;
    logic inside_obj_reg, inside_obj_next;
    logic inside_str_reg, inside_str_next;
    logic escape_reg, escape_next;
    logic dropping_reg, dropping_next;
    logic fatal_reg, fatal_next;
    logic [jsf_pkg::COUNT_W-1:0] level_reg, level_next;
    logic [jsf_pkg::COUNT_W-1:0] kept_reg, kept_next;

    logic [jsf_pkg::COUNT_W-1:0] kc0, kc1, lvl0, lvl_up, lvl_dn;
    logic keep, drop1, raise;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_event_bytes_reg <= jsf_pkg::MAX_EVENT_BYTES_RST;
            max_nesting_reg     <= jsf_pkg::MAX_NESTING_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == jsf_pkg::REG_MAX_EVENT_BYTES)
                max_event_bytes_reg <= cfg_data;
            else if (cfg_index == jsf_pkg::REG_MAX_NESTING)
                max_nesting_reg <= cfg_data[jsf_pkg::NEST_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outer_open_reg <= 1'b0;
            inside_obj_reg <= 1'b0;
            inside_str_reg <= 1'b0;
            escape_reg     <= 1'b0;
            dropping_reg   <= 1'b0;
            fatal_reg      <= 1'b0;
            level_reg      <= '0;
            kept_reg       <= '0;
        end
        else if (push)
        begin
            outer_open_reg <= outer_open_next;
            inside_obj_reg <= inside_obj_next;
            inside_str_reg <= inside_str_next;
            escape_reg     <= escape_next;
            dropping_reg   <= dropping_next;
            fatal_reg      <= fatal_next;
            level_reg      <= level_next;
            kept_reg       <= kept_next;
        end
    end

    // object view as if a new object opened on this byte
    always_comb
    begin
        kc0    = inside_obj_reg ? kept_reg : '0;
        lvl0   = inside_obj_reg ? level_reg : jsf_pkg::COUNT_W'(1);
        keep   = !dropping_reg && (kc0 < max_event_bytes_reg);
        kc1    = keep ? kc0 + jsf_pkg::COUNT_W'(1) : kc0;
        drop1  = dropping_reg || !keep;
        raise  = !((in_byte == jsf_pkg::CH_LBRACE) && (lvl0 == jsf_pkg::COUNT_W'(1))
                 && (kc1 == jsf_pkg::COUNT_W'(1)));
        lvl_up = raise ? lvl0 + jsf_pkg::COUNT_W'(1) : lvl0;
        lvl_dn = lvl0 - jsf_pkg::COUNT_W'(1);
    end

    always_comb
    begin
        outer_open_next = outer_open_reg;
        inside_obj_next = inside_obj_reg;
        inside_str_next = inside_str_reg;
        escape_next     = escape_reg;
        dropping_next   = dropping_reg;
        fatal_next      = fatal_reg;
        level_next      = level_reg;
        kept_next       = kept_reg;

        result.status       = jsf_pkg::ST_SKIP;
        result.data_byte    = in_byte;
        result.byte_kept    = 1'b0;
        result.event_length = '0;

        if (fatal_reg)
        begin
            result.status = jsf_pkg::ST_FATAL;
        end
        else if (!outer_open_reg)
        begin
            if (in_byte == jsf_pkg::CH_LBRACKET)
                outer_open_next = 1'b1;
            else if (!jsf_pkg::is_ws(in_byte))
            begin
                fatal_next    = 1'b1;
                result.status = jsf_pkg::ST_FATAL;
            end
        end
        else if (!inside_obj_reg && (jsf_pkg::is_ws(in_byte)
                 || (in_byte == jsf_pkg::CH_COMMA) || (in_byte == jsf_pkg::CH_RBRACKET)))
        begin
            result.status = jsf_pkg::ST_SKIP;
        end
        else if (!inside_obj_reg && (in_byte != jsf_pkg::CH_LBRACE))
        begin
            fatal_next    = 1'b1;
            result.status = jsf_pkg::ST_FATAL;
        end
        else
        begin
            inside_obj_next  = 1'b1;
            kept_next        = kc1;
            dropping_next    = drop1;
            level_next       = lvl0;
            result.status    = jsf_pkg::ST_BYTE;
            result.byte_kept = keep;
            if (inside_str_reg)
            begin
                if (escape_reg)
                    escape_next = 1'b0;
                else if (in_byte == jsf_pkg::CH_BSLASH)
                    escape_next = 1'b1;
                else if (in_byte == jsf_pkg::CH_QUOTE)
                    inside_str_next = 1'b0;
            end
            else if (in_byte == jsf_pkg::CH_QUOTE)
            begin
                inside_str_next = 1'b1;
            end
            else if ((in_byte == jsf_pkg::CH_LBRACE) || (in_byte == jsf_pkg::CH_LBRACKET))
            begin
                if (raise && (lvl0 >= jsf_pkg::LEVEL_LIMIT))
                begin
                    fatal_next       = 1'b1;
                    result.status    = jsf_pkg::ST_FATAL;
                    result.byte_kept = 1'b0;
                end
                else
                begin
                    level_next = lvl_up;
                    if (lvl_up > {{(jsf_pkg::COUNT_W-jsf_pkg::NEST_W){1'b0}}, max_nesting_reg})
                        dropping_next = 1'b1;
                end
            end
            else if ((in_byte == jsf_pkg::CH_RBRACE) || (in_byte == jsf_pkg::CH_RBRACKET))
            begin
                if (lvl0 == '0)
                begin
                    fatal_next       = 1'b1;
                    result.status    = jsf_pkg::ST_FATAL;
                    result.byte_kept = 1'b0;
                end
                else
                begin
                    level_next = lvl_dn;
                    if (lvl_dn == '0)
                    begin
                        inside_obj_next = 1'b0;
                        inside_str_next = 1'b0;
                        escape_next     = 1'b0;
                        dropping_next   = 1'b0;
                        if (drop1)
                        begin
                            kept_next     = '0;
                            result.status = jsf_pkg::ST_DROP;
                        end
                        else
                        begin
                            result.status       = jsf_pkg::ST_DONE;
                            result.event_length = kc1;
                        end
                    end
                end
            end
        end
    end

endmodule

FILE: sv/jsf_out_buf.sv
`timescale 1ns / 1ps

module jsf_out_buf
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  jsf_pkg::result_t push_data,
    output logic             full,
    output logic             out_valid,
    input  logic             out_stall,
    output jsf_pkg::result_t out_data
);

    logic             main_valid_reg, main_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    jsf_pkg::result_t main_reg, main_next;
    jsf_pkg::result_t skid_reg, skid_next;
    logic             pop;

    assign pop       = main_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = push_data;
                main_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

FILE: sv/json_object_stream_framer_unit.sv
`timescale 1ns / 1ps

// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+-------------------------------------------
// in       | sink      | in_valid/in_stall  | in_byte
// out      | source    | out_valid/out_stall| status, data_byte, byte_kept, event_length
// cfg      | sink      | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one byte per cycle while in_stall is low; each transfer updates the framing state
// and writes its result into the output buffer, where it is registered
// a two-entry output buffer lets input run on while a result waits;
// in_stall rises only when both entries hold results
// rst_n clears state and restores max_event_bytes 4096, max_nesting 16
// cfg_ready is always high

module json_object_stream_framer_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [jsf_pkg::BYTE_W-1:0]    in_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [jsf_pkg::STATUS_W-1:0]  status,
    output logic [jsf_pkg::BYTE_W-1:0]    data_byte,
    output logic                          byte_kept,
    output logic [jsf_pkg::COUNT_W-1:0]   event_length,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [jsf_pkg::INDEX_W-1:0]   cfg_index,
    input  logic [jsf_pkg::COUNT_W-1:0]   cfg_data
);

    logic             push;
    logic             full;
    jsf_pkg::result_t step_result;
    jsf_pkg::result_t out_data;

    assign cfg_ready = 1'b1;
    assign in_stall  = full;
    assign push      = in_valid && !full;

    jsf_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .in_byte   (in_byte),
        .result    (step_result)
    );

    jsf_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (step_result),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign status       = out_data.status;
    assign data_byte    = out_data.data_byte;
    assign byte_kept    = out_data.byte_kept;
    assign event_length = out_data.event_length;

endmodule
